// ===== hdl/twqm_pkg.sv =====
`default_nettype none
package twqm_pkg;
    localparam int NUM_TASKS  = 32;
    localparam int NUM_QUEUES = 8;
    localparam int TW = $clog2(NUM_TASKS);
    localparam int QW = $clog2(NUM_QUEUES);
    localparam int LW = TW + 1;
    localparam int OW = QW + 1;
    localparam logic [LW-1:0] LINK_NULL  = LW'(NUM_TASKS);
    localparam logic [OW-1:0] OWNER_NONE = OW'(NUM_QUEUES);

    typedef enum logic [2:0] {
        ACT_ALLOC   = 3'd0,
        ACT_APPEND  = 3'd1,
        ACT_REMOVE  = 3'd2,
        ACT_POP     = 3'd3,
        ACT_DESTROY = 3'd4,
        ACT_QUERY   = 3'd5
    } t_action;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] queue_id;
        logic [4:0] task_id;
    } t_cmd;

    typedef struct packed {
        logic       is_empty;
        logic [2:0] queue_out;
        logic [4:0] task_out;
        logic       status;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LINK,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== hdl/twqm_front.sv =====
`default_nettype none
module twqm_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire twqm_pkg::t_cmd  i_cmd,
    output logic                 o_valid,
    input  wire                  i_ready,
    output twqm_pkg::t_cmd       o_cmd
);
    // two-entry queue
    twqm_pkg::t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/twqm_back.sv =====
`default_nettype none
module twqm_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire twqm_pkg::t_cmd  i_cmd,
    output logic                 o_valid,
    input  wire                  i_ready,
    output twqm_pkg::t_rsp       o_rsp
);
    localparam int NT = twqm_pkg::NUM_TASKS;
    localparam int NQ = twqm_pkg::NUM_QUEUES;
    localparam int TW = twqm_pkg::TW;
    localparam int QW = twqm_pkg::QW;
    localparam int LW = twqm_pkg::LW;
    localparam int OW = twqm_pkg::OW;

    logic [NQ-1:0] r_inuse;
    logic [LW-1:0] r_head [NQ];
    logic [LW-1:0] r_tail [NQ];
    logic [LW-1:0] r_next [NT];
    logic [LW-1:0] r_prev [NT];
    logic [OW-1:0] r_owner [NT];

    twqm_pkg::t_state r_st, n_st;
    twqm_pkg::t_cmd r_cmd;
    logic [TW-1:0] r_t;          // task being unlinked
    logic [QW-1:0] r_q;          // queue of that task
    logic [LW-1:0] r_p, r_n;
    logic r_walk;                // destroy walk active
    twqm_pkg::t_rsp r_rsp;
    logic r_ov;

    assign o_valid = r_ov;
    assign o_rsp = r_rsp;
    assign o_ready = (r_st == twqm_pkg::ST_IDLE) && !r_ov;

    logic [QW-1:0] cq;
    logic [TW-1:0] ct;
    logic q_ok, t_ok;
    logic [QW-1:0] free_q;
    logic free_ok;
    logic need_link;
    assign cq = r_cmd.queue_id[QW-1:0];
    assign ct = r_cmd.task_id[TW-1:0];
    assign q_ok = (32'(r_cmd.queue_id) < NQ) && r_inuse[cq];
    assign t_ok = 32'(r_cmd.task_id) < NT;

    // commands that unlink at least one node
    assign need_link =
        (r_cmd.action == twqm_pkg::ACT_REMOVE && t_ok
            && r_owner[ct] != twqm_pkg::OWNER_NONE)
        || (r_cmd.action == twqm_pkg::ACT_POP && q_ok
            && r_head[cq] != twqm_pkg::LINK_NULL)
        || (r_cmd.action == twqm_pkg::ACT_DESTROY && q_ok
            && r_head[cq] != twqm_pkg::LINK_NULL);

    always_comb begin
        free_ok = 1'b0;
        free_q = '0;
        for (int i = NQ - 1; i >= 0; i--) begin
            if (!r_inuse[i]) begin
                free_ok = 1'b1;
                free_q = QW'(i);
            end
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            twqm_pkg::ST_IDLE: begin
                if (i_valid && o_ready) begin
                    n_st = twqm_pkg::ST_READ;
                end
            end
            twqm_pkg::ST_READ: begin
                if (need_link) begin
                    n_st = twqm_pkg::ST_LINK;
                end else begin
                    n_st = twqm_pkg::ST_DONE;
                end
            end
            twqm_pkg::ST_LINK: begin
                if (!(r_walk && r_n != twqm_pkg::LINK_NULL)) begin
                    n_st = twqm_pkg::ST_DONE;
                end
            end
            twqm_pkg::ST_DONE: n_st = twqm_pkg::ST_IDLE;
            default: n_st = twqm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= twqm_pkg::ST_IDLE;
            r_ov <= 1'b0;
            r_walk <= 1'b0;
            r_inuse <= '0;
            for (int i = 0; i < NQ; i++) begin
                r_head[i] <= twqm_pkg::LINK_NULL;
                r_tail[i] <= twqm_pkg::LINK_NULL;
            end
            for (int i = 0; i < NT; i++) begin
                r_next[i] <= twqm_pkg::LINK_NULL;
                r_prev[i] <= twqm_pkg::LINK_NULL;
                r_owner[i] <= twqm_pkg::OWNER_NONE;
            end
        end else begin
            r_st <= n_st;
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                twqm_pkg::ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd <= i_cmd;
                    end
                end
                twqm_pkg::ST_READ: begin
                    r_rsp <= '0;
                    r_rsp.status <= 1'b1;
                    r_walk <= 1'b0;
                    unique case (r_cmd.action)
                        twqm_pkg::ACT_ALLOC: if (free_ok) begin
                            r_inuse[free_q] <= 1'b1;
                            r_head[free_q] <= twqm_pkg::LINK_NULL;
                            r_tail[free_q] <= twqm_pkg::LINK_NULL;
                            r_rsp.status <= 1'b0;
                            r_rsp.queue_out <= 3'(free_q);
                            r_rsp.is_empty <= 1'b1;
                        end
                        twqm_pkg::ACT_APPEND: begin
                            r_rsp.is_empty <= !q_ok || r_head[cq] == twqm_pkg::LINK_NULL;
                            if (q_ok && t_ok && r_owner[ct] == twqm_pkg::OWNER_NONE) begin
                                r_owner[ct] <= OW'(cq);
                                r_next[ct] <= twqm_pkg::LINK_NULL;
                                r_prev[ct] <= r_tail[cq];
                                if (r_tail[cq] == twqm_pkg::LINK_NULL)
                                    r_head[cq] <= LW'(ct);
                                else
                                    r_next[r_tail[cq][TW-1:0]] <= LW'(ct);
                                r_tail[cq] <= LW'(ct);
                                r_rsp.status <= 1'b0;
                                r_rsp.is_empty <= 1'b0;
                            end
                        end
                        twqm_pkg::ACT_REMOVE: if (t_ok) begin
                            r_rsp.status <= 1'b0;
                            if (r_owner[ct] != twqm_pkg::OWNER_NONE) begin
                                r_t <= ct;
                                r_q <= r_owner[ct][QW-1:0];
                                r_p <= r_prev[ct];
                                r_n <= r_next[ct];
                            end
                        end
                        twqm_pkg::ACT_POP: begin
                            r_rsp.is_empty <= 1'b1;
                            if (q_ok && r_head[cq] != twqm_pkg::LINK_NULL) begin
                                r_t <= r_head[cq][TW-1:0];
                                r_q <= cq;
                                r_p <= twqm_pkg::LINK_NULL;
                                r_n <= r_next[r_head[cq][TW-1:0]];
                                r_rsp.status <= 1'b0;
                                r_rsp.task_out <= 5'(r_head[cq][TW-1:0]);
                            end
                        end
                        twqm_pkg::ACT_DESTROY: begin
                            r_rsp.is_empty <= 1'b1;
                            if (q_ok) begin
                                r_rsp.status <= 1'b0;
                                if (r_head[cq] == twqm_pkg::LINK_NULL) begin
                                    r_inuse[cq] <= 1'b0;
                                    r_tail[cq] <= twqm_pkg::LINK_NULL;
                                end else begin
                                    r_t <= r_head[cq][TW-1:0];
                                    r_q <= cq;
                                    r_p <= twqm_pkg::LINK_NULL;
                                    r_n <= r_next[r_head[cq][TW-1:0]];
                                    r_walk <= 1'b1;
                                end
                            end
                        end
                        twqm_pkg::ACT_QUERY: begin
                            r_rsp.status <= !q_ok;
                            r_rsp.is_empty <= !q_ok || r_head[cq] == twqm_pkg::LINK_NULL;
                        end
                        default: ;
                    endcase
                end
                twqm_pkg::ST_LINK: begin
                    // unlink r_t from queue r_q
                    if (r_p == twqm_pkg::LINK_NULL) r_head[r_q] <= r_n;
                    else r_next[r_p[TW-1:0]] <= r_n;
                    if (r_n == twqm_pkg::LINK_NULL) r_tail[r_q] <= r_p;
                    else r_prev[r_n[TW-1:0]] <= r_p;
                    r_owner[r_t] <= twqm_pkg::OWNER_NONE;
                    r_prev[r_t] <= twqm_pkg::LINK_NULL;
                    r_next[r_t] <= twqm_pkg::LINK_NULL;
                    if (r_cmd.action == twqm_pkg::ACT_REMOVE || r_cmd.action == twqm_pkg::ACT_POP)
                        r_rsp.is_empty <= (r_p == twqm_pkg::LINK_NULL)
                                          && (r_n == twqm_pkg::LINK_NULL);
                    if (r_walk && r_n != twqm_pkg::LINK_NULL) begin
                        r_t <= r_n[TW-1:0];
                        r_n <= r_next[r_n[TW-1:0]];
                    end else begin
                        if (r_walk) r_inuse[r_q] <= 1'b0;
                    end
                end
                twqm_pkg::ST_DONE: begin
                    r_ov <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/task_wait_queue_manager_unit.sv =====
// task wait queue manager: fifo wait queues over 32 task slots
// input word on s_axis: action, queue id, task id
// output word on m_axis: status, popped task, allocated queue, empty flag
// one result word for every input word, in order
// an accepted word passes the command queue, then the back-end states READ and DONE;
// a remove or pop that unlinks a task also passes LINK; a destroy stays in LINK to walk
// over the queue's links, one node per cycle
// the back-end sequencer handles one word at a time
// a two-word command queue takes words while the back end is busy
// the back end holds a result until m_axis_tready; it starts no new word
// until its result is taken
// synchronous active-low reset empties the queues, frees all queues and
// clears every task node
`default_nettype none
module task_wait_queue_manager_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,  // action[2:0], queue_id[5:3], task_id[10:6]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata   // status[0], task_out[5:1], queue_out[8:6], is_empty[9]
);
    twqm_pkg::t_cmd in_cmd, q_cmd;
    twqm_pkg::t_rsp rsp;
    logic q_valid, q_ready;
    logic unused;

    assign in_cmd.action   = s_axis_tdata[2:0];
    assign in_cmd.queue_id = s_axis_tdata[5:3];
    assign in_cmd.task_id  = s_axis_tdata[10:6];
    assign unused = ^s_axis_tdata[15:11];

    twqm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    twqm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_rsp(rsp)
    );

    assign m_axis_tdata = {6'd0, rsp.is_empty, rsp.queue_out, rsp.task_out, rsp.status};
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    task_wait_queue_manager_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    typedef struct {
        logic       status;
        logic [4:0] task_out;
        logic [2:0] queue_out;
        logic       is_empty;
    } t_result;

    // shadow of the queue lists
    logic                     q_used [twqm_pkg::NUM_QUEUES];
    logic [twqm_pkg::LW-1:0]  q_head [twqm_pkg::NUM_QUEUES];
    logic [twqm_pkg::LW-1:0]  q_tail [twqm_pkg::NUM_QUEUES];
    logic [twqm_pkg::LW-1:0]  t_next [twqm_pkg::NUM_TASKS];
    logic [twqm_pkg::LW-1:0]  t_prev [twqm_pkg::NUM_TASKS];
    logic [twqm_pkg::OW-1:0]  t_own  [twqm_pkg::NUM_TASKS];

    t_result pending_results[$];
    int      errors;
    int      cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void clear_lists();
        for (int i = 0; i < twqm_pkg::NUM_QUEUES; i++) begin
            q_used[i] = 1'b0;
            q_head[i] = twqm_pkg::LINK_NULL;
            q_tail[i] = twqm_pkg::LINK_NULL;
        end
        for (int i = 0; i < twqm_pkg::NUM_TASKS; i++) begin
            t_next[i] = twqm_pkg::LINK_NULL;
            t_prev[i] = twqm_pkg::LINK_NULL;
            t_own[i]  = twqm_pkg::OWNER_NONE;
        end
    endfunction

    function automatic void unlink(int t);
        int q;
        logic [twqm_pkg::LW-1:0] p;
        logic [twqm_pkg::LW-1:0] n;
        q = t_own[t];
        p = t_prev[t];
        n = t_next[t];
        if (p == twqm_pkg::LINK_NULL) begin
            q_head[q] = n;
        end else begin
            t_next[p] = n;
        end
        if (n == twqm_pkg::LINK_NULL) begin
            q_tail[q] = p;
        end else begin
            t_prev[n] = p;
        end
        t_own[t]  = twqm_pkg::OWNER_NONE;
        t_prev[t] = twqm_pkg::LINK_NULL;
        t_next[t] = twqm_pkg::LINK_NULL;
    endfunction

    function automatic logic list_empty(int q);
        return q_head[q] == twqm_pkg::LINK_NULL;
    endfunction

    function automatic t_result apply_action(logic [2:0] act, logic [2:0] q, logic [4:0] t);
        t_result r;
        logic    q_ok;
        int      owner;
        r = '{1'b1, 5'd0, 3'd0, 1'b0};
        q_ok = q_used[q];
        case (act)
            twqm_pkg::ACT_ALLOC: begin
                for (int i = 0; i < twqm_pkg::NUM_QUEUES; i++) begin
                    if (!q_used[i] && r.status) begin
                        q_used[i] = 1'b1;
                        q_head[i] = twqm_pkg::LINK_NULL;
                        q_tail[i] = twqm_pkg::LINK_NULL;
                        r.status = 1'b0;
                        r.queue_out = 3'(i);
                        r.is_empty = 1'b1;
                    end
                end
            end
            twqm_pkg::ACT_APPEND: begin
                if (q_ok && t_own[t] == twqm_pkg::OWNER_NONE) begin
                    t_own[t]  = twqm_pkg::OW'(q);
                    t_next[t] = twqm_pkg::LINK_NULL;
                    t_prev[t] = q_tail[q];
                    if (q_tail[q] == twqm_pkg::LINK_NULL) begin
                        q_head[q] = twqm_pkg::LW'(t);
                    end else begin
                        t_next[q_tail[q]] = twqm_pkg::LW'(t);
                    end
                    q_tail[q] = twqm_pkg::LW'(t);
                    r.status = 1'b0;
                end
                r.is_empty = list_empty(q);
            end
            twqm_pkg::ACT_REMOVE: begin
                r.status = 1'b0;
                if (t_own[t] != twqm_pkg::OWNER_NONE) begin
                    owner = t_own[t];
                    unlink(t);
                    r.is_empty = list_empty(owner);
                end
            end
            twqm_pkg::ACT_POP: begin
                if (q_ok && q_head[q] != twqm_pkg::LINK_NULL) begin
                    r.task_out = 5'(q_head[q]);
                    unlink(q_head[q]);
                    r.status = 1'b0;
                end
                r.is_empty = list_empty(q);
            end
            twqm_pkg::ACT_DESTROY: begin
                if (q_ok) begin
                    while (q_head[q] != twqm_pkg::LINK_NULL) begin
                        unlink(q_head[q]);
                    end
                    q_tail[q] = twqm_pkg::LINK_NULL;
                    q_used[q] = 1'b0;
                    r.status = 1'b0;
                end
                r.is_empty = list_empty(q);
            end
            twqm_pkg::ACT_QUERY: begin
                if (q_ok) begin
                    r.status = 1'b0;
                end
                r.is_empty = list_empty(q);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_word(logic [2:0] act, logic [2:0] q, logic [4:0] t);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, t, q, act};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(apply_action(act, q, t));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
    endtask

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[0] !== exp_r.status) begin
                    $error("status expected %0d got %0d", exp_r.status, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[5:1] !== exp_r.task_out) begin
                    $error("task_out expected %0d got %0d", exp_r.task_out,
                           m_axis_tdata[5:1]);
                    errors++;
                end
                if (m_axis_tdata[8:6] !== exp_r.queue_out) begin
                    $error("queue_out expected %0d got %0d", exp_r.queue_out,
                           m_axis_tdata[8:6]);
                    errors++;
                end
                if (m_axis_tdata[9] !== exp_r.is_empty) begin
                    $error("is_empty expected %0d got %0d", exp_r.is_empty, m_axis_tdata[9]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("task_wait_queue_manager_unit test failed");
            $finish;
        end
    end

    task automatic test_directed();
        for (int i = 0; i < 9; i++) send_word(twqm_pkg::ACT_ALLOC, 3'd0, 5'd0);
        send_word(twqm_pkg::ACT_APPEND, 3'd7, 5'd31);
        send_word(twqm_pkg::ACT_APPEND, 3'd7, 5'd0);
        send_word(twqm_pkg::ACT_APPEND, 3'd0, 5'd31);
        send_word(twqm_pkg::ACT_APPEND, 3'd7, 5'd15);
        send_word(twqm_pkg::ACT_REMOVE, 3'd0, 5'd0);
        send_word(twqm_pkg::ACT_REMOVE, 3'd0, 5'd7);
        send_word(twqm_pkg::ACT_POP, 3'd7, 5'd0);
        send_word(twqm_pkg::ACT_POP, 3'd7, 5'd0);
        send_word(twqm_pkg::ACT_QUERY, 3'd7, 5'd0);
        send_word(twqm_pkg::ACT_DESTROY, 3'd7, 5'd0);
        send_word(twqm_pkg::ACT_APPEND, 3'd7, 5'd3);
        send_word(twqm_pkg::ACT_POP, 3'd7, 5'd0);
        send_word(twqm_pkg::ACT_QUERY, 3'd7, 5'd0);
        send_word(3'd6, 3'd5, 5'd21);
        send_word(3'd7, 3'd2, 5'd10);
        drain();
    endtask

    // appends are the most common action so lists get long
    task automatic random_word();
        logic [2:0] act;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 5) act = twqm_pkg::ACT_ALLOC;
        else if (pick < 45) act = twqm_pkg::ACT_APPEND;
        else if (pick < 60) act = twqm_pkg::ACT_REMOVE;
        else if (pick < 80) act = twqm_pkg::ACT_POP;
        else if (pick < 85) act = twqm_pkg::ACT_DESTROY;
        else if (pick < 97) act = twqm_pkg::ACT_QUERY;
        else act = 3'($urandom_range(6, 7));
        send_word(act, 3'($urandom_range(7)), 5'($urandom_range(31)));
    endtask

    task automatic test_random_phase(int idle, int stall, int count);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++) random_word();
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 300;
        for (int i = 0; i < 30; i++) random_word();
        drain();
    endtask

    initial begin
        errors         = 0;
        cycles         = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        clear_lists();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(0, 0, 180);
        test_random_phase(51, 0, 170);
        test_random_phase(0, 51, 170);
        test_random_phase(38, 38, 170);
        test_backpressure();
        if (errors == 0) begin
            $display("task_wait_queue_manager_unit test passed");
        end else begin
            $display("task_wait_queue_manager_unit test failed");
        end
        $finish;
    end
endmodule
